/* rtl/sse_pkg.sv */
package sse_pkg;

    // request operation carried in s_tuser
    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_ASCEND  = 2'd2,
        OP_DESCEND = 2'd3
    } op_t;

    // result kind carried in m_tuser
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_DELETED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_LISTED    = 3'd5,
        ST_EMPTY     = 3'd6
    } status_t;

    localparam int VALUE_W = 32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;     // latch request operation and value
        logic compare;     // register the row-wide compare results
        logic update;      // apply insert or delete and load the result
        logic emit_empty;  // load the empty-listing result
        logic emit_list;   // load the head cell as a listed value
        logic list_last;   // the listed value is the final one
        logic rot_left;    // rotate the whole row toward cell 0
        logic rot_right;   // rotate the whole row away from cell 0
        logic rot_ring;    // rotate the occupied cells toward cell 0
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        op_t  op;          // operation of the request being worked on
        logic out_free;    // result register can take a new result
    } dp_status_t;

endpackage

/* rtl/sorted_set_engine.sv */
// sorted set engine: keeps up to CAPACITY distinct signed 32-bit values in
// ascending order in a row of cells that compare against a request in parallel.
// input channel: s_tuser carries the operation (insert, delete, list ascending,
// list descending), s_tdata the value. result channel: m_tuser carries the
// status, m_tdata the value, m_tlast marks the final result of a request.
// insert and delete give one result; the result register is loaded in the
// update step after the compare step, and a following request is taken in the
// same cycle as that load, so a request is taken before the last result leaves.
// an ascending listing of n values emits one value per cycle while the result
// register is free, after a compare step; a descending listing first rotates the
// row until its largest value heads it; an empty listing gives one empty result.
// reset (aresetn low, synchronous) empties the set and drops any pending result.
// when m_tready is low the single result register holds and the engine waits;
// no request is taken while a listing is in progress.
module sorted_set_engine #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // item
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    sse_pkg::cmd_t       cmd;
    sse_pkg::dp_status_t stat;
    logic [OCC_W-1:0]    occ;

    // sequencing of requests and listings
    sse_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .occ      (occ),
        .cmd      (cmd)
    );

    // cell row, compare results and result register
    sse_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .occ      (occ),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/sse_datapath.sv */
module sse_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [31:0]                     s_tdata,   // value
    input  logic [1:0]                      s_tuser,   // operation
    input  sse_pkg::cmd_t                   cmd,
    output sse_pkg::dp_status_t             stat,
    output logic [$clog2(CAPACITY+1)-1:0]   occ,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // item
    output logic [2:0]                      m_tuser,   // status
    output logic                            m_tlast
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    // row of sorted cells, slots below the occupancy are valid
    logic signed [sse_pkg::VALUE_W-1:0] row_reg  [CAPACITY];
    logic signed [sse_pkg::VALUE_W-1:0] row_next [CAPACITY];

    logic [CAPACITY-1:0] lt_reg;
    logic [CAPACITY-1:0] lt_next;
    logic [CAPACITY-1:0] eq_reg;
    logic [CAPACITY-1:0] eq_next;
    logic [CAPACITY-1:0] prev_lt;

    sse_pkg::op_t                       op_reg;
    logic signed [sse_pkg::VALUE_W-1:0] val_reg;
    logic [OCC_W-1:0]                   occ_reg;
    logic [OCC_W-1:0]                   occ_next;
    logic [OCC_W-1:0]                   occ_last;

    logic                               out_valid_reg;
    sse_pkg::status_t                   out_status_reg;
    sse_pkg::status_t                   out_status_next;
    logic signed [sse_pkg::VALUE_W-1:0] out_item_reg;
    logic signed [sse_pkg::VALUE_W-1:0] out_item_next;
    logic                               out_last_reg;
    logic                               out_last_next;

    logic dup;
    logic full;
    logic do_ins;
    logic do_del;
    logic load;

    assign dup      = |eq_reg;
    assign full     = (occ_reg >= OCC_W'(CAPACITY));
    assign do_ins   = cmd.update && (op_reg == sse_pkg::OP_INSERT) && !dup && !full;
    assign do_del   = cmd.update && (op_reg == sse_pkg::OP_DELETE) && dup;
    assign occ_last = occ_reg - OCC_W'(1);
    assign load     = cmd.update || cmd.emit_empty || cmd.emit_list;

    // per-cell compare and shift logic
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam int NXT = (i + 1) % CAPACITY;
        localparam int PRV = (i + CAPACITY - 1) % CAPACITY;

        assign lt_next[i] = (OCC_W'(i) < occ_reg) && (row_reg[i] < val_reg);
        assign eq_next[i] = (OCC_W'(i) < occ_reg) && (row_reg[i] == val_reg);

        if (i == 0) begin : g_head
            assign prev_lt[i] = 1'b1;
        end else begin : g_body
            assign prev_lt[i] = lt_reg[i-1];
        end

        always_comb begin
            row_next[i] = row_reg[i];
            if (do_ins) begin
                // cells at and above the insert point move up one
                if (!lt_reg[i]) begin
                    row_next[i] = prev_lt[i] ? val_reg : row_reg[PRV];
                end
            end else if (do_del) begin
                // cells from the match point take their upper neighbor
                if (!lt_reg[i]) begin
                    row_next[i] = row_reg[NXT];
                end
            end else if (cmd.rot_left) begin
                row_next[i] = row_reg[NXT];
            end else if (cmd.rot_right) begin
                row_next[i] = row_reg[PRV];
            end else if (cmd.rot_ring) begin
                row_next[i] = (OCC_W'(i) == occ_last) ? row_reg[0] : row_reg[NXT];
            end
        end
    end

    // occupancy update
    always_comb begin
        occ_next = occ_reg;
        if (do_ins) begin
            occ_next = occ_reg + OCC_W'(1);
        end else if (do_del) begin
            occ_next = occ_last;
        end
    end

    // result selection
    always_comb begin
        out_item_next = val_reg;
        out_last_next = 1'b1;
        if (cmd.emit_list) begin
            out_status_next = sse_pkg::ST_LISTED;
            out_item_next   = row_reg[0];
            out_last_next   = cmd.list_last;
        end else if (cmd.emit_empty) begin
            out_status_next = sse_pkg::ST_EMPTY;
        end else begin
            case (op_reg)
                sse_pkg::OP_INSERT: begin
                    if (dup) begin
                        out_status_next = sse_pkg::ST_DUPLICATE;
                    end else if (full) begin
                        out_status_next = sse_pkg::ST_FULL;
                    end else begin
                        out_status_next = sse_pkg::ST_INSERTED;
                    end
                end
                sse_pkg::OP_DELETE: begin
                    out_status_next = dup ? sse_pkg::ST_DELETED : sse_pkg::ST_NOT_FOUND;
                end
                default: begin
                    out_status_next = sse_pkg::ST_EMPTY;
                end
            endcase
        end
    end

    // cell row and request registers
    always_ff @(posedge aclk) begin
        row_reg <= row_next;
        if (cmd.capture) begin
            op_reg  <= sse_pkg::op_t'(s_tuser);
            val_reg <= s_tdata;
        end
        if (cmd.compare) begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
        if (load) begin
            out_status_reg <= out_status_next;
            out_item_reg   <= out_item_next;
            out_last_reg   <= out_last_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.op       = op_reg;
    assign stat.out_free = !out_valid_reg || m_tready;
    assign occ           = occ_reg;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_item_reg;
    assign m_tuser       = out_status_reg;
    assign m_tlast       = out_last_reg;

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    a_occ_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(occ_reg)) |-> $past(cmd.update))
        else $error("occupancy changed without an update");

    a_delete_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        do_del |=> (occ_reg == $past(occ_last)))
        else $error("delete did not shrink the set");
`endif

endmodule

/* rtl/sse_ctrl.sv */
module sse_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  sse_pkg::dp_status_t             stat,
    input  logic [$clog2(CAPACITY+1)-1:0]   occ,
    output sse_pkg::cmd_t                   cmd
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_EMPTY,
        S_SEEK,
        S_LIST
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [OCC_W-1:0] cnt_reg;
    logic [OCC_W-1:0] cnt_next;
    logic             accept;
    logic             is_last;

    // a new request is taken when idle or while the single result is handed off
    assign s_tready = (state_reg == S_IDLE) ||
                      (((state_reg == S_UPD) || (state_reg == S_EMPTY)) && stat.out_free);
    assign accept   = s_tvalid && s_tready;
    assign is_last  = (cnt_reg == (occ - OCC_W'(1)));

    // next state and datapath commands
    always_comb begin
        cmd         = '0;
        cmd.capture = accept;
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                cmd.compare = 1'b1;
                cnt_next    = '0;
                if ((stat.op == sse_pkg::OP_INSERT) || (stat.op == sse_pkg::OP_DELETE)) begin
                    state_next = S_UPD;
                end else if (occ == '0) begin
                    state_next = S_EMPTY;
                end else if ((stat.op == sse_pkg::OP_ASCEND) || (occ == OCC_W'(1))) begin
                    state_next = S_LIST;
                end else begin
                    state_next = S_SEEK;
                end
            end
            S_UPD: begin
                if (stat.out_free) begin
                    cmd.update = 1'b1;
                    state_next = accept ? S_CMP : S_IDLE;
                end
            end
            S_EMPTY: begin
                if (stat.out_free) begin
                    cmd.emit_empty = 1'b1;
                    state_next     = accept ? S_CMP : S_IDLE;
                end
            end
            S_SEEK: begin
                // bring the largest value to the head cell
                cmd.rot_left = 1'b1;
                cnt_next     = cnt_reg + OCC_W'(1);
                if (cnt_reg == (occ - OCC_W'(2))) begin
                    cnt_next   = '0;
                    state_next = S_LIST;
                end
            end
            S_LIST: begin
                if (stat.out_free) begin
                    cmd.emit_list = 1'b1;
                    cmd.list_last = is_last;
                    if (stat.op == sse_pkg::OP_ASCEND) begin
                        cmd.rot_ring = 1'b1;
                    end else begin
                        cmd.rot_right = !is_last;
                    end
                    cnt_next = cnt_reg + OCC_W'(1);
                    if (is_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTH
    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.compare, cmd.update, cmd.emit_empty, cmd.emit_list}))
        else $error("conflicting datapath commands");

    a_result_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.update || cmd.emit_empty || cmd.emit_list) |-> stat.out_free)
        else $error("result loaded over a pending result");

    a_list_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST) |-> (cnt_reg < occ))
        else $error("listing ran past the stored values");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int CAPACITY      = 64;
    localparam int SETTLE_CYCLES = 200;

    // one request as it travels on the input channel
    typedef struct packed {
        sse_pkg::op_t op;
        logic [31:0]  value;
        logic         drain;   // hold off until every expected result is back
    } request_t;

    // one result as it travels on the result channel
    typedef struct packed {
        sse_pkg::status_t status;
        logic [31:0]      item;
        logic             last;
    } result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // value
    logic [1:0]  s_tuser  = '0;   // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;    // item
    logic [2:0]  m_tuser;    // status
    logic        m_tlast;

    request_t    request_q[$];
    result_t     expected_q[$];
    logic [31:0] inserted_vals[$];
    int          set_vals[CAPACITY];
    int          set_count   = 0;
    int          n_launched  = 0;
    int          n_accepted  = 0;
    int          error_count = 0;
    int unsigned cyc         = 0;

    sorted_set_engine #(
        .CAPACITY(CAPACITY)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // 12 ns clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // long window where neither side idles
    function automatic bit quiet_phase();
        return (cyc >= 300) && (cyc < 500);
    endfunction

    function automatic void push_result(sse_pkg::status_t st, logic [31:0] item, logic last);
        result_t r;
        r.status = st;
        r.item   = item;
        r.last   = last;
        expected_q.push_back(r);
    endfunction

    // sorted set behavior: update the set and queue the results of one request
    function automatic void predict_results(request_t req);
        int v;
        int pos;
        int i;
        int idx;
        v   = $signed(req.value);
        pos = 0;
        while (pos < set_count && set_vals[pos] < v)
            pos++;
        case (req.op)
            sse_pkg::OP_INSERT: begin
                if (pos < set_count && set_vals[pos] == v) begin
                    push_result(sse_pkg::ST_DUPLICATE, req.value, 1'b1);
                end else if (set_count >= CAPACITY) begin
                    push_result(sse_pkg::ST_FULL, req.value, 1'b1);
                end else begin
                    for (i = set_count; i > pos; i--)
                        set_vals[i] = set_vals[i - 1];
                    set_vals[pos] = v;
                    set_count++;
                    push_result(sse_pkg::ST_INSERTED, req.value, 1'b1);
                end
            end
            sse_pkg::OP_DELETE: begin
                if (pos < set_count && set_vals[pos] == v) begin
                    for (i = pos; i + 1 < set_count; i++)
                        set_vals[i] = set_vals[i + 1];
                    set_count--;
                    push_result(sse_pkg::ST_DELETED, req.value, 1'b1);
                end else begin
                    push_result(sse_pkg::ST_NOT_FOUND, req.value, 1'b1);
                end
            end
            default: begin
                if (set_count == 0) begin
                    push_result(sse_pkg::ST_EMPTY, req.value, 1'b1);
                end else begin
                    for (i = 0; i < set_count; i++) begin
                        idx = (req.op == sse_pkg::OP_ASCEND) ? i : set_count - 1 - i;
                        push_result(sse_pkg::ST_LISTED, set_vals[idx], i == set_count - 1);
                    end
                end
            end
        endcase
    endfunction

    function automatic void add_request(sse_pkg::op_t op, logic [31:0] value,
                                        logic drain = 1'b0);
        request_t req;
        req.op    = op;
        req.value = value;
        req.drain = drain;
        request_q.push_back(req);
        if (op == sse_pkg::OP_INSERT)
            inserted_vals.push_back(value);
    endfunction

    // value mix: small values collide often, full-range ones cover every bit
    function automatic logic [31:0] pick_value(sse_pkg::op_t op);
        int sel;
        sel = $urandom_range(99);
        if (op == sse_pkg::OP_DELETE && sel < 50 && inserted_vals.size() != 0)
            return inserted_vals[$urandom_range(inserted_vals.size() - 1)];
        if (sel < 75)
            return int'($urandom_range(16)) - 8;
        return $urandom();
    endfunction

    // input driver: presents queued requests with random gaps
    always @(negedge aclk) begin
        cyc <= cyc + 1;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && n_accepted != n_launched) begin
            // transaction still waiting for s_tready
        end else if (request_q.size() != 0
                     && !(request_q[0].drain && expected_q.size() != 0)
                     && (quiet_phase() || $urandom_range(99) >= 26)) begin
            s_tdata    <= request_q[0].value;
            s_tuser    <= request_q[0].op;
            s_tvalid   <= 1'b1;
            n_launched <= n_launched + 1;
            void'(request_q.pop_front());
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result side backpressure
    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= quiet_phase() || ($urandom_range(99) >= 26);
    end

    // monitor: predict on accepted requests, check every accepted result
    always @(posedge aclk) begin
        request_t seen;
        result_t  want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                seen.op    = sse_pkg::op_t'(s_tuser);
                seen.value = s_tdata;
                seen.drain = 1'b0;
                predict_results(seen);
                n_accepted++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, %s %0d item %0d last %0b",
                             $time, "got status", m_tuser, $signed(m_tdata), m_tlast);
                    error_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_tuser !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, m_tuser);
                        error_count++;
                    end
                    if (m_tdata !== want.item) begin
                        $display("%0t: item mismatch, expected %0d, got %0d",
                                 $time, $signed(want.item), $signed(m_tdata));
                        error_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: last mismatch, expected %0b, got %0b",
                                 $time, want.last, m_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [31:0]  r;
        sse_pkg::op_t op;
        int           k;

        // directed: empty listings, extremes, duplicates, head and tail deletes
        add_request(sse_pkg::OP_ASCEND,  32'h7FFF_FFFF);
        add_request(sse_pkg::OP_DESCEND, 32'h8000_0000);
        add_request(sse_pkg::OP_DELETE,  32'h0000_0005);
        add_request(sse_pkg::OP_INSERT,  32'h0000_0000);
        add_request(sse_pkg::OP_INSERT,  32'h8000_0000);
        add_request(sse_pkg::OP_INSERT,  32'h7FFF_FFFF);
        add_request(sse_pkg::OP_INSERT,  32'hFFFF_FFFF);
        add_request(sse_pkg::OP_INSERT,  32'h0000_0001);
        add_request(sse_pkg::OP_INSERT,  32'hAAAA_AAAA);
        add_request(sse_pkg::OP_INSERT,  32'h5555_5555);
        add_request(sse_pkg::OP_INSERT,  32'h0000_0000);
        add_request(sse_pkg::OP_INSERT,  32'h7FFF_FFFF);
        add_request(sse_pkg::OP_ASCEND,  32'h1234_5678);
        add_request(sse_pkg::OP_DESCEND, 32'hFFFF_FFFF);
        add_request(sse_pkg::OP_DELETE,  32'h7FFF_FFFF);
        add_request(sse_pkg::OP_DELETE,  32'h8000_0000);
        add_request(sse_pkg::OP_DELETE,  32'h0000_002A);
        add_request(sse_pkg::OP_DELETE,  32'h0000_0001);
        add_request(sse_pkg::OP_ASCEND,  32'h0000_0000);
        add_request(sse_pkg::OP_DESCEND, 32'h0000_0000, 1'b1);

        // random mix of all operations
        for (k = 0; k < 8; k++) begin
            op = sse_pkg::op_t'($urandom_range(3));
            add_request(op, pick_value(op), $urandom_range(14) == 0);
        end

        // fill the set to capacity with distinct values, listing along the way
        for (k = 0; k < CAPACITY; k++) begin
            r = $urandom();
            add_request(sse_pkg::OP_INSERT, {r[31:6], 6'(k)}, k == 0);
            if (k % 16 == 15)
                add_request(sse_pkg::op_t'($urandom_range(3, 2)), $urandom());
        end

        // full set: duplicate wins over full, then full listings
        add_request(sse_pkg::OP_INSERT, inserted_vals[inserted_vals.size() - CAPACITY]);
        r = $urandom();
        add_request(sse_pkg::OP_INSERT, {r[31:6], 6'd0} ^ 32'h0000_0040);
        add_request(sse_pkg::OP_INSERT, 32'h8000_0000);
        add_request(sse_pkg::OP_ASCEND, $urandom());
        add_request(sse_pkg::OP_DESCEND, $urandom());

        // drain part of the set again
        for (k = 0; k < 8; k++) begin
            op = ($urandom_range(3) == 0) ? sse_pkg::op_t'($urandom_range(3))
                                          : sse_pkg::OP_DELETE;
            add_request(op, pick_value(op));
        end
        add_request(sse_pkg::OP_DESCEND, $urandom());

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        do
            @(posedge aclk);
        while (request_q.size() != 0 || s_tvalid);
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hard stop if the run hangs
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
